// ===== rtl/h8mov_pkg.sv =====
// Shared types and constants of the H8/300H-style MOV subset executor.
`default_nettype none

package h8mov_pkg;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_LOAD    = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_HALTED  = 3'd3,
    ST_PROTO   = 3'd4
  } status_t;

  localparam logic [1:0] KIND_RESTART   = 2'd0;
  localparam logic [1:0] KIND_INSTR     = 2'd1;
  localparam logic [1:0] KIND_LOAD_DATA = 2'd2;

  localparam logic [7:0] OP_NOP        = 8'h00;
  localparam logic [7:0] OP_MOVB       = 8'h0C;
  localparam logic [7:0] OP_MOVW       = 8'h0D;
  localparam logic [7:0] OP_MOVL       = 8'h0F;
  localparam logic [7:0] OP_LD_IND     = 8'h68;
  localparam logic [7:0] OP_LD_POSTINC = 8'h6C;
  localparam logic [7:0] OP_LD_D16     = 8'h6E;
  localparam logic [7:0] OP_LD_D24     = 8'h78;
  localparam logic [3:0] OP_MOVB_IMM   = 4'hF;

  // fixed bytes of the @(d24,ERs) form
  localparam logic [7:0] D24_BYTE2    = 8'h6A;
  localparam logic [3:0] D24_BYTE3_HI = 4'h2;
  localparam logic [7:0] D24_BYTE4    = 8'h00;

  localparam logic [3:0] COST_REG     = 4'd2;
  localparam logic [3:0] COST_IND     = 4'd4;
  localparam logic [3:0] COST_D16     = 4'd6;
  localparam logic [3:0] COST_POSTINC = 4'd6;
  localparam logic [3:0] COST_D24     = 4'd10;

  localparam logic [3:0] LEN_SHORT = 4'd2;
  localparam logic [3:0] LEN_D16   = 4'd4;
  localparam logic [3:0] LEN_D24   = 4'd8;

  localparam logic [7:0] CCR_RESET = 8'h80;

endpackage

`default_nettype wire

// ===== rtl/h8_mov_instruction_executor.sv =====
// Top level of the H8/300H-style MOV subset executor.
//
// One input channel (item_valid / item_stall) carries an item of kind restart,
// instruction bytes or load data reply; one output channel (result_valid /
// result_stall) returns exactly one result per item. A transfer happens on a
// rising edge with valid high and stall low.
// Each item is decoded, reads the register file and updates all state in the
// cycle of its transfer; its result sits in the output register in the next
// cycle. Throughput is 1 item per cycle unless the receiver stalls, set by
// the single decode / register-read / add path ahead of the output register.
// A load instruction answers with a load request; the data comes back later
// as a load data item, which then writes the register and the flags.
// While the result register is full and the receiver stalls, item_stall is
// raised and no item is taken; the held result does not change.
// Synchronous reset clears all registers, PC and counter, sets CCR to 0x80
// and empties the output register. A restart item clears the same state and
// loads the PC from reset_vector. An unknown opcode halts the block until restart.
`default_nettype none

module h8_mov_instruction_executor #(
  parameter int COUNTER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  byte0,
  input  wire logic [7:0]  byte1,
  input  wire logic [7:0]  byte2,
  input  wire logic [7:0]  byte3,
  input  wire logic [7:0]  byte4,
  input  wire logic [7:0]  byte5,
  input  wire logic [7:0]  byte6,
  input  wire logic [7:0]  byte7,
  input  wire logic [7:0]  load_data,
  input  wire logic [23:0] reset_vector,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [2:0]       status,
  output logic [23:0]      load_address,
  output logic [23:0]      pc_now,
  output logic [7:0]       ccr_now,
  output logic [31:0]      cycle_count,
  output logic [2:0]       written_reg,
  output logic [31:0]      written_value
);
  import h8mov_pkg::*;

  // architectural state
  logic [31:0]             regs [8];
  logic [23:0]             pc;
  logic [7:0]              ccr;
  logic [COUNTER_BITS-1:0] cycles;
  logic                    pend;
  logic [3:0]              pend_dest;
  logic [2:0]              pend_base;
  logic                    pend_postinc;
  logic [3:0]              pend_cost;
  logic                    stopped;

  logic [31:0]             regs_next [8];
  logic [23:0]             pc_next;
  logic [7:0]              ccr_next;
  logic [COUNTER_BITS-1:0] cycles_next;
  logic                    pend_next;
  logic [3:0]              pend_dest_next;
  logic [2:0]              pend_base_next;
  logic                    pend_postinc_next;
  logic [3:0]              pend_cost_next;
  logic                    stopped_next;

  // per-item decode and result values
  status_t     st;
  logic [23:0] addr;
  logic [2:0]  wreg;
  logic [31:0] wval;
  logic        wrote;
  logic [3:0]  cost;
  logic [3:0]  len;
  logic        is_load;
  logic [23:0] ld_off;
  logic [3:0]  ld_dest;
  logic        ld_postinc;
  logic [3:0]  ld_cost;
  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [3:0]  mvd;
  logic [7:0]  mv8;
  logic [15:0] mv16;
  logic [31:0] mv32;
  logic        accept;

  function automatic logic [7:0] get_byte(input logic [31:0] r, input logic low);
    return low ? r[7:0] : r[15:8];
  endfunction

  function automatic logic [31:0] put_byte(input logic [31:0] r, input logic low,
                                           input logic [7:0] v);
    return low ? {r[31:8], v} : {r[31:16], v, r[7:0]};
  endfunction

  function automatic logic [15:0] get_word(input logic [31:0] r, input logic ext);
    return ext ? r[31:16] : r[15:0];
  endfunction

  function automatic logic [31:0] put_word(input logic [31:0] r, input logic ext,
                                           input logic [15:0] v);
    return ext ? {v, r[15:0]} : {r[31:16], v};
  endfunction

  // N and Z from the moved value, V cleared, rest kept
  function automatic logic [7:0] set_nz(input logic [7:0] f, input logic neg,
                                        input logic zero);
    return {f[7:4], neg, zero, 1'b0, f[0]};
  endfunction

  assign hi         = byte1[7:4];
  assign lo         = byte1[3:0];
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    regs_next         = regs;
    pc_next           = pc;
    ccr_next          = ccr;
    cycles_next       = cycles;
    pend_next         = pend;
    pend_dest_next    = pend_dest;
    pend_base_next    = pend_base;
    pend_postinc_next = pend_postinc;
    pend_cost_next    = pend_cost;
    stopped_next      = stopped;
    st         = ST_DONE;
    addr       = '0;
    wreg       = '0;
    wrote      = 1'b0;
    cost       = '0;
    len        = '0;
    is_load    = 1'b0;
    ld_off     = '0;
    ld_dest    = lo;
    ld_postinc = 1'b0;
    ld_cost    = '0;
    mvd        = lo;
    mv8        = get_byte(regs[hi[2:0]], hi[3]);
    mv16       = get_word(regs[hi[2:0]], hi[3]);
    mv32       = regs[hi[2:0]];

    if (kind == KIND_RESTART) begin
      for (int i = 0; i < 8; i++) begin
        regs_next[i] = '0;
      end
      pc_next           = reset_vector;
      ccr_next          = CCR_RESET;
      cycles_next       = '0;
      pend_next         = 1'b0;
      pend_dest_next    = '0;
      pend_base_next    = '0;
      pend_postinc_next = 1'b0;
      pend_cost_next    = '0;
      stopped_next      = 1'b0;
    end else if (stopped) begin
      st = ST_HALTED;
    end else if (kind == KIND_LOAD_DATA && pend) begin
      regs_next[pend_dest[2:0]] = put_byte(regs[pend_dest[2:0]], pend_dest[3], load_data);
      wreg = pend_dest[2:0];
      // base bump lands after the byte write, also when base and dest match
      if (pend_postinc) begin
        regs_next[pend_base] = regs_next[pend_base] + 32'd1;
        wreg = pend_base;
      end
      wrote     = 1'b1;
      ccr_next  = set_nz(ccr, load_data[7], load_data == 8'd0);
      cost      = pend_cost;
      pend_next = 1'b0;
    end else if (kind != KIND_INSTR || pend) begin
      st = ST_PROTO;
    end else begin
      case (byte0)
        OP_NOP: begin
          cost = COST_REG;
          len  = LEN_SHORT;
        end
        OP_MOVB: begin
          regs_next[mvd[2:0]] = put_byte(regs[mvd[2:0]], mvd[3], mv8);
          ccr_next = set_nz(ccr, mv8[7], mv8 == 8'd0);
          wreg  = mvd[2:0];
          wrote = 1'b1;
          cost  = COST_REG;
          len   = LEN_SHORT;
        end
        OP_MOVW: begin
          regs_next[lo[2:0]] = put_word(regs[lo[2:0]], lo[3], mv16);
          ccr_next = set_nz(ccr, mv16[15], mv16 == 16'd0);
          wreg  = lo[2:0];
          wrote = 1'b1;
          cost  = COST_REG;
          len   = LEN_SHORT;
        end
        OP_MOVL: begin
          regs_next[lo[2:0]] = mv32;
          ccr_next = set_nz(ccr, mv32[31], mv32 == 32'd0);
          wreg  = lo[2:0];
          wrote = 1'b1;
          cost  = COST_REG;
          len   = LEN_SHORT;
        end
        OP_LD_IND: begin
          is_load = 1'b1;
          ld_cost = COST_IND;
          len     = LEN_SHORT;
        end
        OP_LD_POSTINC: begin
          is_load    = 1'b1;
          ld_postinc = 1'b1;
          ld_cost    = COST_POSTINC;
          len        = LEN_SHORT;
        end
        OP_LD_D16: begin
          is_load = 1'b1;
          ld_off  = {{8{byte2[7]}}, byte2, byte3};
          ld_cost = COST_D16;
          len     = LEN_D16;
        end
        OP_LD_D24: begin
          if (byte2 == D24_BYTE2 && byte3[7:4] == D24_BYTE3_HI && byte4 == D24_BYTE4) begin
            is_load = 1'b1;
            ld_off  = {byte5, byte6, byte7};
            ld_dest = byte3[3:0];
            ld_cost = COST_D24;
            len     = LEN_D24;
          end else begin
            stopped_next = 1'b1;
            st           = ST_ILLEGAL;
          end
        end
        default: begin
          if (byte0[7:4] == OP_MOVB_IMM) begin
            // immediate form: destination in the opcode, value in byte1
            mvd = byte0[3:0];
            regs_next[mvd[2:0]] = put_byte(regs[mvd[2:0]], mvd[3], byte1);
            ccr_next = set_nz(ccr, byte1[7], byte1 == 8'd0);
            wreg  = mvd[2:0];
            wrote = 1'b1;
            cost  = COST_REG;
            len   = LEN_SHORT;
          end else begin
            stopped_next = 1'b1;
            st           = ST_ILLEGAL;
          end
        end
      endcase

      if (is_load) begin
        st                = ST_LOAD;
        addr              = mv32[23:0] + ld_off;
        pend_next         = 1'b1;
        pend_dest_next    = ld_dest;
        pend_base_next    = hi[2:0];
        pend_postinc_next = ld_postinc;
        pend_cost_next    = ld_cost;
      end
    end

    if (kind != KIND_RESTART) begin
      pc_next     = pc + 24'(len);
      cycles_next = cycles + COUNTER_BITS'(cost);
    end
    wval = wrote ? regs_next[wreg] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= '0;
      end
      pc           <= '0;
      ccr          <= CCR_RESET;
      cycles       <= '0;
      pend         <= 1'b0;
      pend_dest    <= '0;
      pend_base    <= '0;
      pend_postinc <= 1'b0;
      pend_cost    <= '0;
      stopped      <= 1'b0;
    end else if (accept) begin
      regs         <= regs_next;
      pc           <= pc_next;
      ccr          <= ccr_next;
      cycles       <= cycles_next;
      pend         <= pend_next;
      pend_dest    <= pend_dest_next;
      pend_base    <= pend_base_next;
      pend_postinc <= pend_postinc_next;
      pend_cost    <= pend_cost_next;
      stopped      <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= st;
      load_address  <= addr;
      pc_now        <= pc_next;
      ccr_now       <= ccr_next;
      cycle_count   <= 32'(cycles_next);
      written_reg   <= wreg;
      written_value <= wval;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/h8mov_checker.sv =====
// Port-level assertions for the MOV subset executor, bound to the top level.
`default_nettype none

module h8mov_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_stall,
  input wire logic [1:0]  kind,
  input wire logic [23:0] reset_vector,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [2:0]  status,
  input wire logic [23:0] load_address,
  input wire logic [23:0] pc_now,
  input wire logic [7:0]  ccr_now,
  input wire logic [31:0] cycle_count,
  input wire logic [2:0]  written_reg,
  input wire logic [31:0] written_value
);
  import h8mov_pkg::*;

  // a stalled result stays and holds its status, PC, cycle count and written value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) &&
      $stable(pc_now) && $stable(written_value) && $stable(cycle_count))
    else $error("stalled result changed");

  // every transferred item has its result valid in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("result missing after item transfer");

  // restart brings back the reset state with the new PC
  a_restart: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind == KIND_RESTART |=>
      status == ST_DONE && pc_now == $past(reset_vector) && ccr_now == CCR_RESET &&
      cycle_count == 32'd0 && written_reg == 3'd0 && written_value == 32'd0)
    else $error("restart result wrong");

  // address is only shown with a load request
  a_addr: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_LOAD |-> load_address == 24'd0)
    else $error("load address without load request");

endmodule

bind h8_mov_instruction_executor h8mov_checker u_h8mov_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .kind         (kind),
  .reset_vector (reset_vector),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .load_address (load_address),
  .pc_now       (pc_now),
  .ccr_now      (ccr_now),
  .cycle_count  (cycle_count),
  .written_reg  (written_reg),
  .written_value(written_value)
);

`default_nettype wire

// ===== tb/sv/h8_mov_instruction_executor_tb.sv =====
// Self-checking testbench for the H8/300H-style MOV subset executor.
module h8_mov_instruction_executor_tb;
  import h8mov_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    status_t     st;
    logic [23:0] addr;
    logic [23:0] pc;
    logic [7:0]  ccr;
    logic [31:0] cyc;
    logic [2:0]  wreg;
    logic [31:0] wval;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  kind = '0;
  logic [7:0]  byte0 = '0, byte1 = '0, byte2 = '0, byte3 = '0;
  logic [7:0]  byte4 = '0, byte5 = '0, byte6 = '0, byte7 = '0;
  logic [7:0]  load_data = '0;
  logic [23:0] reset_vector = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  status;
  logic [23:0] load_address;
  logic [23:0] pc_now;
  logic [7:0]  ccr_now;
  logic [31:0] cycle_count;
  logic [2:0]  written_reg;
  logic [31:0] written_value;

  // predicted CPU state
  logic [31:0] gpr [8];
  logic [23:0] pc;
  logic [7:0]  ccr;
  logic [31:0] cycles;
  logic        ld_busy, ld_postinc, halted;
  logic [3:0]  ld_dest, ld_cost;
  logic [2:0]  ld_base;

  exec_result_t exec_results_due [$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  rx_hold_cycles = 0;
  bit  gaps_on = 1'b1;

  h8_mov_instruction_executor dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .kind(kind),
    .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
    .byte4(byte4), .byte5(byte5), .byte6(byte6), .byte7(byte7),
    .load_data(load_data), .reset_vector(reset_vector),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .load_address(load_address), .pc_now(pc_now),
    .ccr_now(ccr_now), .cycle_count(cycle_count),
    .written_reg(written_reg), .written_value(written_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void model_reset(logic [23:0] vec);
    foreach (gpr[i]) gpr[i] = '0;
    pc = vec;
    ccr = CCR_RESET;
    cycles = '0;
    ld_busy = 1'b0;
    ld_dest = '0;
    ld_base = '0;
    ld_postinc = 1'b0;
    ld_cost = '0;
    halted = 1'b0;
  endfunction

  function automatic void set_nz(logic neg, logic zero);
    ccr = {ccr[7:4], neg, zero, 1'b0, ccr[0]};
  endfunction

  // nibble bit 3 picks RnL, else RnH
  function automatic void put_byte(logic [3:0] nib, logic [7:0] v);
    if (nib[3]) gpr[nib[2:0]][7:0] = v;
    else gpr[nib[2:0]][15:8] = v;
  endfunction

  // PC moves now; flags, cost and post-increment wait for the data
  function automatic logic [23:0] begin_load(logic [31:0] off, logic [3:0] base,
                                             logic [3:0] dest, logic inc,
                                             logic [3:0] cost, logic [3:0] len);
    logic [31:0] sum;
    sum = gpr[base[2:0]] + off;
    ld_busy = 1'b1;
    ld_dest = dest;
    ld_base = base[2:0];
    ld_postinc = inc;
    ld_cost = cost;
    pc += 24'(len);
    return sum[23:0];
  endfunction

  function automatic exec_result_t execute_item(logic [1:0] k, logic [7:0][7:0] b,
                                                logic [7:0] ld, logic [23:0] vec);
    exec_result_t r;
    logic        wrote, reg_op;
    logic [3:0]  hi, lo, dn;
    logic [7:0]  v8;
    logic [15:0] v16;
    logic [31:0] v32;
    r.st = ST_DONE;
    r.addr = '0;
    r.wreg = '0;
    r.wval = '0;
    wrote = 1'b0;
    reg_op = 1'b0;
    hi = b[1][7:4];
    lo = b[1][3:0];
    if (k == KIND_RESTART) begin
      model_reset(vec);
    end else if (halted) begin
      r.st = ST_HALTED;
    end else if (k == KIND_LOAD_DATA && ld_busy) begin
      put_byte(ld_dest, ld);
      r.wreg = ld_dest[2:0];
      if (ld_postinc) begin
        gpr[ld_base] = gpr[ld_base] + 32'd1;
        r.wreg = ld_base;
      end
      wrote = 1'b1;
      set_nz(ld[7], ld == 8'd0);
      cycles += 32'(ld_cost);
      ld_busy = 1'b0;
    end else if (k != KIND_INSTR || ld_busy) begin
      r.st = ST_PROTO;
    end else if (b[0] == OP_NOP) begin
      reg_op = 1'b1;
    end else if (b[0] == OP_MOVB || b[0][7:4] == OP_MOVB_IMM) begin
      if (b[0] == OP_MOVB) begin
        v8 = hi[3] ? gpr[hi[2:0]][7:0] : gpr[hi[2:0]][15:8];
        dn = lo;
      end else begin
        v8 = b[1];
        dn = b[0][3:0];
      end
      put_byte(dn, v8);
      set_nz(v8[7], v8 == 8'd0);
      r.wreg = dn[2:0];
      wrote = 1'b1;
      reg_op = 1'b1;
    end else if (b[0] == OP_MOVW) begin
      v16 = hi[3] ? gpr[hi[2:0]][31:16] : gpr[hi[2:0]][15:0];
      if (lo[3]) gpr[lo[2:0]][31:16] = v16;
      else gpr[lo[2:0]][15:0] = v16;
      set_nz(v16[15], v16 == 16'd0);
      r.wreg = lo[2:0];
      wrote = 1'b1;
      reg_op = 1'b1;
    end else if (b[0] == OP_MOVL) begin
      v32 = gpr[hi[2:0]];
      gpr[lo[2:0]] = v32;
      set_nz(v32[31], v32 == 32'd0);
      r.wreg = lo[2:0];
      wrote = 1'b1;
      reg_op = 1'b1;
    end else if (b[0] == OP_LD_IND) begin
      r.addr = begin_load(32'd0, hi, lo, 1'b0, COST_IND, LEN_SHORT);
      r.st = ST_LOAD;
    end else if (b[0] == OP_LD_POSTINC) begin
      r.addr = begin_load(32'd0, hi, lo, 1'b1, COST_POSTINC, LEN_SHORT);
      r.st = ST_LOAD;
    end else if (b[0] == OP_LD_D16) begin
      r.addr = begin_load({{16{b[2][7]}}, b[2], b[3]}, hi, lo, 1'b0, COST_D16, LEN_D16);
      r.st = ST_LOAD;
    end else if (b[0] == OP_LD_D24 && b[2] == D24_BYTE2 && b[3][7:4] == D24_BYTE3_HI
                 && b[4] == D24_BYTE4) begin
      r.addr = begin_load({8'd0, b[5], b[6], b[7]}, hi, b[3][3:0], 1'b0, COST_D24, LEN_D24);
      r.st = ST_LOAD;
    end else begin
      halted = 1'b1;
      r.st = ST_ILLEGAL;
    end
    if (reg_op) begin
      cycles += 32'(COST_REG);
      pc += 24'(LEN_SHORT);
    end
    if (wrote) r.wval = gpr[r.wreg];
    r.pc = pc;
    r.ccr = ccr;
    r.cyc = cycles;
    return r;
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    exec_result_t want;
    if (rst) begin
      model_reset(24'd0);
    end else begin
      if (item_valid && !item_stall)
        exec_results_due.push_back(execute_item(kind,
          {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0}, load_data, reset_vector));
      if (result_valid && !result_stall) begin
        if (exec_results_due.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = exec_results_due.pop_front();
          check_field("status", 32'(status), 32'(want.st));
          check_field("load_address", 32'(load_address), 32'(want.addr));
          check_field("pc_now", 32'(pc_now), 32'(want.pc));
          check_field("ccr_now", 32'(ccr_now), 32'(want.ccr));
          check_field("cycle_count", cycle_count, want.cyc);
          check_field("written_reg", 32'(written_reg), 32'(want.wreg));
          check_field("written_value", written_value, want.wval);
        end
      end
    end
  end

  // result side: random stall bursts, or one long hold when asked
  always begin
    @(posedge clk);
    if (rx_hold_cycles > 0) begin
      result_stall <= 1'b1;
      repeat (rx_hold_cycles) @(posedge clk);
      rx_hold_cycles = 0;
      result_stall <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      repeat ($urandom_range(1, 17)) @(posedge clk);
      result_stall <= 1'b0;
    end
  end

  // ----------------------------------------------------------------- stimulus

  function automatic logic [47:0] rand_tail();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [23:0] rand_vector();
    if ($urandom_range(0, 3) == 0) return 24'hFFFFFF - 24'($urandom_range(0, 15));
    return 24'($urandom);
  endfunction

  task automatic send_item(logic [1:0] k, logic [7:0] b0, logic [7:0] b1, logic [47:0] tail,
                           logic [7:0] ld, logic [23:0] vec);
    item_valid <= 1'b1;
    kind <= k;
    byte0 <= b0;
    byte1 <= b1;
    {byte2, byte3, byte4, byte5, byte6, byte7} <= tail;
    load_data <= ld;
    reset_vector <= vec;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [7:0] b0, logic [7:0] b1, logic [47:0] tail);
    send_item(KIND_INSTR, b0, b1, tail, 8'($urandom), 24'($urandom));
  endtask

  task automatic send_data(logic [7:0] d);
    send_item(KIND_LOAD_DATA, 8'($urandom), 8'($urandom), rand_tail(), d, 24'($urandom));
  endtask

  task automatic send_restart(logic [23:0] vec);
    send_item(KIND_RESTART, 8'($urandom), 8'($urandom), rand_tail(), 8'($urandom), vec);
  endtask

  task automatic wait_all_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (exec_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_load();
    logic [7:0] b1;
    b1 = 8'($urandom);
    case ($urandom_range(0, 3))
      0: send_op(OP_LD_IND, b1, rand_tail());
      1: send_op(OP_LD_POSTINC, b1, rand_tail());
      2: send_op(OP_LD_D16, b1, rand_tail());
      default: send_op(OP_LD_D24, b1, {D24_BYTE2, D24_BYTE3_HI, 4'($urandom), D24_BYTE4,
                                       24'($urandom)});
    endcase
    // occasionally something the block must refuse while the load is open
    case ($urandom_range(0, 19))
      0: send_op(8'($urandom), 8'($urandom), rand_tail());
      1: send_item(KIND_UNUSED, 8'($urandom), 8'($urandom), rand_tail(), 8'($urandom),
                   24'($urandom));
      default: ;
    endcase
    send_data(8'($urandom));
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_op(OP_NOP, 8'($urandom), rand_tail());
    end else if (pick < 14) begin
      send_op(OP_MOVB, 8'($urandom), rand_tail());
    end else if (pick < 24) begin
      send_op(OP_MOVW, 8'($urandom), rand_tail());
    end else if (pick < 32) begin
      send_op(OP_MOVL, 8'($urandom), rand_tail());
    end else if (pick < 44) begin
      send_op({OP_MOVB_IMM, 4'($urandom)}, 8'($urandom), rand_tail());
    end else if (pick < 90) begin
      random_load();
    end else if (pick < 93) begin
      if ($urandom_range(0, 1) == 0) send_data(8'($urandom));
      else send_item(KIND_UNUSED, 8'($urandom), 8'($urandom), rand_tail(), 8'($urandom),
                     24'($urandom));
    end else if (pick < 96) begin
      // likely illegal: random opcode or a d24 form with random fixed bytes
      if ($urandom_range(0, 1) == 0) send_op(8'($urandom), 8'($urandom), rand_tail());
      else send_op(OP_LD_D24, 8'($urandom), rand_tail());
      repeat ($urandom_range(0, 3))
        send_item(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), rand_tail(),
                  8'($urandom), 24'($urandom));
      send_restart(rand_vector());
    end else begin
      send_restart(rand_vector());
    end
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_register_moves();
    send_restart(24'hFFFFFE);
    send_op(OP_NOP, 8'hFF, rand_tail());                     // PC wraps to 0
    send_op({OP_MOVB_IMM, 4'h8}, 8'hFF, rand_tail());        // R0L, negative
    send_op({OP_MOVB_IMM, 4'h0}, 8'h00, rand_tail());        // R0H, zero
    send_op({OP_MOVB_IMM, 4'hF}, 8'h80, rand_tail());        // R7L
    send_op(OP_MOVB, 8'h83, rand_tail());                    // R0L -> R3H
    send_op(OP_MOVW, 8'h7F, rand_tail());                    // R7 -> E7
    send_op(OP_MOVW, 8'hF0, rand_tail());                    // E7 -> R0
    send_op(OP_MOVL, 8'h7A, rand_tail());                    // dest index masked
    send_op(OP_MOVL, 8'hF8, rand_tail());
  endtask

  task automatic test_loads();
    send_op(OP_LD_IND, 8'h7B, rand_tail());
    send_data(8'h80);
    send_op(OP_LD_D16, 8'h2C, {16'h8000, 32'($urandom)});    // most negative d16
    send_data(8'h00);
    send_op(OP_LD_D16, 8'h05, {16'h7FFF, 32'($urandom)});
    send_data(8'hFF);
    send_op(OP_LD_D24, 8'h70, {D24_BYTE2, D24_BYTE3_HI, 4'hE, D24_BYTE4, 24'hFFFFFF});
    send_data(8'h5A);
    send_op(OP_LD_POSTINC, 8'h7F, rand_tail());              // base is also dest
    send_data(8'hFF);
    send_op(OP_LD_POSTINC, 8'h30, rand_tail());
    send_data(8'h01);
  endtask

  task automatic test_protocol_errors();
    send_data(8'h33);                                        // no load open
    send_item(KIND_UNUSED, 8'h00, 8'h00, rand_tail(), 8'h00, 24'h0);
    send_op(OP_LD_IND, 8'h12, rand_tail());
    send_op(OP_NOP, 8'h00, rand_tail());                     // load still open
    send_data(8'h44);
  endtask

  task automatic test_halt_and_restart();
    send_op(OP_LD_D24, 8'h10, {8'h6B, 8'h21, 8'h00, 24'h000001});
    send_op(OP_NOP, 8'h00, rand_tail());
    send_data(8'h11);
    send_item(KIND_UNUSED, 8'h00, 8'h00, rand_tail(), 8'h00, 24'h0);
    send_restart(24'h000100);
    send_op(8'h01, 8'h00, rand_tail());
    send_restart(24'h000000);
  endtask

  // result side holds while the sender keeps offering, then the sender waits out
  task automatic test_backpressure();
    wait_all_results();
    gaps_on = 1'b0;
    rx_hold_cycles = 120;
    repeat (15) random_step();
    gaps_on = 1'b1;
    wait_all_results();
  endtask

  task automatic test_random(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (40) random_step();
    end
  endtask

  task automatic test_back_to_back(int n);
    int stop_at;
    gaps_on = 1'b0;
    stop_at = items_sent + n;
    while (items_sent < stop_at) random_step();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_moves();
    test_loads();
    test_protocol_errors();
    test_halt_and_restart();
    test_backpressure();
    test_random(1600);
    test_back_to_back(300);
    wait_all_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && exec_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/h8mov_pkg.sv
rtl/h8_mov_instruction_executor.sv
rtl/h8mov_checker.sv
tb/sv/h8_mov_instruction_executor_tb.sv
